// File: src/koren_lg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and records for the limited gradient pipeline.
// No dependencies; every other file uses this package.
package koren_lg_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int LIM_WIDTH  = FRAC_BITS + 3;
    localparam int QUO_WIDTH  = FRAC_BITS + 2;
    localparam int DIV_WIDTH  = DATA_WIDTH + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (QUO_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int THIRD_W    = (FRAC_BITS % 2 == 1) ? FRAC_BITS + 4 : FRAC_BITS + 5;
    localparam int PROD_W     = LIM_WIDTH - 1 + DATA_WIDTH;
    localparam int SHIFTED_W  = PROD_W - FRAC_BITS;

    localparam int ONE      = 1 << FRAC_BITS;
    localparam int CLAMP_LO = -(2 << FRAC_BITS);
    localparam int CLAMP_HI = 5 << (FRAC_BITS - 1);
    localparam int PHI_MIN  = -((2 << FRAC_BITS) / 3);
    localparam int PHI_MAX  = 2 << FRAC_BITS;

    localparam logic [THIRD_W-1:0] THIRD_MUL =
        THIRD_W'(((64'd1 << THIRD_W) + 64'd1) / 64'd3);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [LIM_WIDTH-1:0]  lim_t;
    typedef logic [QUO_WIDTH-1:0]         quo_t;
    typedef logic [DIV_WIDTH-1:0]         dvsr_t;

    typedef struct packed {
        lim_t  phi_base;
        logic  rpos;
        dvsr_t dvsr;
        data_t grad;
        logic  last;
    } lim_item_t;

    typedef struct packed {
        quo_t  quo;
        lim_t  phi_base;
        logic  rpos;
        data_t grad;
        logic  last;
    } div_item_t;

endpackage

// File: src/koren_lg_in_if.sv
`timescale 1ns / 1ps
// Input channel: slope ratio, gradient component and last marker.
// Depends on koren_lg_pkg for field types.
interface koren_lg_in_if;
    logic                  valid;
    logic                  ready;
    koren_lg_pkg::data_t   slope_ratio;
    koren_lg_pkg::data_t   gradient_in;
    logic                  last_component;

    modport source (output valid, output slope_ratio, output gradient_in,
                    output last_component, input ready);
    modport sink   (input valid, input slope_ratio, input gradient_in,
                    input last_component, output ready);
endinterface

// File: src/koren_lg_out_if.sv
`timescale 1ns / 1ps
// Result channel: limited gradient, limiter value, saturation flag, last marker.
// Depends on koren_lg_pkg for field types.
interface koren_lg_out_if;
    logic                  valid;
    logic                  ready;
    koren_lg_pkg::data_t   limited_gradient;
    koren_lg_pkg::lim_t    limiter_value;
    logic                  saturated;
    logic                  last_out;

    modport source (output valid, output limited_gradient, output limiter_value,
                    output saturated, output last_out, input ready);
    modport sink   (input valid, input limited_gradient, input limiter_value,
                    input saturated, input last_out, output ready);
endinterface

// File: src/koren_limited_gradient_top.sv
`timescale 1ns / 1ps
// Top level of the Koren-type limited gradient unit and its configuration register.
// Depends on koren_lg_pkg, the two channel interfaces, koren_lg_phi/div/mul.
//
// Each transfer on sample carries one component (slope ratio r, gradient g, both
// signed Q16.16); one result per component appears on limited, in order. The unit
// takes one component per cycle while limited does not stall, and each result passes
// through 3 stages that form the base limiter (clamp, multiply by one third, min/max),
// 9 stages that run the 4/(1+r) divider at two quotient bits per stage, and 4 stages
// that apply the bound, multiply by g and saturate. Every stage holds its own valid bit
// and advances when empty or when the stage after it moves, so a stall on limited
// fills bubbles first and loses nothing. cfg_wr_en writes bit cfg_wr_data as the
// ratio-side enable (reset 1); write it only while no component is in flight.
module koren_limited_gradient_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    koren_lg_in_if.sink     sample,
    koren_lg_out_if.source  limited
);
    import koren_lg_pkg::*;

    logic      ratio_en_reg;
    logic      phi_valid, phi_ready;
    lim_item_t phi_item;
    logic      div_valid, div_ready;
    div_item_t div_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_en_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            ratio_en_reg <= cfg_wr_data;
        end
    end

    koren_lg_phi u_phi (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_valid (phi_valid),
        .out_ready (phi_ready),
        .out_item  (phi_item)
    );

    koren_lg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (phi_valid),
        .in_ready  (phi_ready),
        .in_item   (phi_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    koren_lg_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .ratio_en  (ratio_en_reg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_item   (div_item),
        .limited   (limited)
    );

endmodule

// File: src/koren_lg_phi.sv
`timescale 1ns / 1ps
// Three-stage front end: clamp the ratio, divide by three, form the base limiter.
// Depends on koren_lg_pkg and koren_lg_in_if.
module koren_lg_phi (
    input  logic                    clk,
    input  logic                    rst_n,
    koren_lg_in_if.sink             sample,
    output logic                    out_valid,
    input  logic                    out_ready,
    output koren_lg_pkg::lim_item_t out_item
);
    import koren_lg_pkg::*;

    logic rdy1, rdy2, rdy3;

    // stage 1
    logic  v1_reg;
    lim_t  rc_reg, rc_next;
    logic  rpos1_reg, rpos1_next;
    dvsr_t dvsr1_reg, dvsr1_next;
    data_t grad1_reg;
    logic  last1_reg;

    // stage 2
    logic                   v2_reg;
    logic [2*THIRD_W-1:0]   prod_mid_reg, prod_mid_next;
    logic [2*THIRD_W-1:0]   prod_four_reg, prod_four_next;
    logic                   mid_neg_reg, mid_neg_next;
    logic                   rpos2_reg;
    dvsr_t                  dvsr2_reg;
    data_t                  grad2_reg;
    logic                   last2_reg;

    logic signed [LIM_WIDTH:0] rc_ext, mid_num;
    logic [THIRD_W-1:0]        mid_mag, four_mag;

    // stage 3
    logic      v3_reg;
    lim_item_t item3_reg, item3_next;
    lim_t      mid, q_four, lo_cl, t_min;

    assign rdy3         = !v3_reg || out_ready;
    assign rdy2         = !v2_reg || rdy3;
    assign rdy1         = !v1_reg || rdy2;
    assign sample.ready = rdy1;

    always_comb
    begin
        rpos1_next = sample.slope_ratio > data_t'(0);
        if (sample.slope_ratio < data_t'(CLAMP_LO))
        begin
            rc_next = lim_t'(CLAMP_LO);
        end
        else if (sample.slope_ratio > data_t'(CLAMP_HI))
        begin
            rc_next = lim_t'(CLAMP_HI);
        end
        else
        begin
            rc_next = lim_t'(sample.slope_ratio);
        end
        dvsr1_next = rpos1_next ? dvsr_t'(sample.slope_ratio) + dvsr_t'(ONE)
                                : dvsr_t'(ONE);
    end

    always_comb
    begin
        rc_ext         = {rc_reg[LIM_WIDTH-1], rc_reg};
        mid_num        = rc_ext + rc_ext + (LIM_WIDTH+1)'(ONE);
        mid_neg_next   = mid_num[LIM_WIDTH];
        mid_mag        = mid_neg_next ? THIRD_W'(-mid_num) : THIRD_W'(mid_num);
        four_mag       = rpos1_reg ? THIRD_W'({rc_reg, 2'b00}) : '0;
        prod_mid_next  = (2*THIRD_W)'(mid_mag) * (2*THIRD_W)'(THIRD_MUL);
        prod_four_next = (2*THIRD_W)'(four_mag) * (2*THIRD_W)'(THIRD_MUL);
    end

    always_comb
    begin
        mid    = mid_neg_reg ? lim_t'(0) - lim_t'(prod_mid_reg[2*THIRD_W-1:THIRD_W])
                             : lim_t'(prod_mid_reg[2*THIRD_W-1:THIRD_W]);
        q_four = lim_t'(prod_four_reg[2*THIRD_W-1:THIRD_W]);
        lo_cl  = (mid < lim_t'(PHI_MIN)) ? lim_t'(PHI_MIN) : mid;
        t_min  = (q_four < mid) ? q_four : mid;
        item3_next.phi_base = rpos2_reg
                            ? ((t_min > lim_t'(PHI_MAX)) ? lim_t'(PHI_MAX) : t_min)
                            : ((lo_cl > lim_t'(0)) ? lim_t'(0) : lo_cl);
        item3_next.rpos = rpos2_reg;
        item3_next.dvsr = dvsr2_reg;
        item3_next.grad = grad2_reg;
        item3_next.last = last2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= sample.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && sample.valid)
        begin
            rc_reg    <= rc_next;
            rpos1_reg <= rpos1_next;
            dvsr1_reg <= dvsr1_next;
            grad1_reg <= sample.gradient_in;
            last1_reg <= sample.last_component;
        end
        if (rdy2 && v1_reg)
        begin
            prod_mid_reg  <= prod_mid_next;
            prod_four_reg <= prod_four_next;
            mid_neg_reg   <= mid_neg_next;
            rpos2_reg     <= rpos1_reg;
            dvsr2_reg     <= dvsr1_reg;
            grad2_reg     <= grad1_reg;
            last2_reg     <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            item3_reg <= item3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

// File: src/koren_lg_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the 4/(1+r) bound, two quotient bits a stage.
// Depends on koren_lg_pkg.
module koren_lg_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  koren_lg_pkg::lim_item_t in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output koren_lg_pkg::div_item_t out_item
);
    import koren_lg_pkg::*;

    logic [DIV_STAGES-1:0] v_reg;
    logic [DIV_STAGES:0]   rdy;
    logic [DIV_STAGES-1:0] v_src;

    dvsr_t     rem_reg  [DIV_STAGES];
    dvsr_t     rem_src  [DIV_STAGES];
    dvsr_t     rem_next [DIV_STAGES];
    quo_t      quo_reg  [DIV_STAGES];
    quo_t      quo_src  [DIV_STAGES];
    quo_t      quo_next [DIV_STAGES];
    lim_item_t item_reg [DIV_STAGES];
    lim_item_t item_src [DIV_STAGES];

    always_comb
    begin
        v_src[0]    = in_valid;
        rem_src[0]  = dvsr_t'(ONE);
        quo_src[0]  = '0;
        item_src[0] = in_item;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            v_src[s]    = v_reg[s-1];
            rem_src[s]  = rem_reg[s-1];
            quo_src[s]  = quo_reg[s-1];
            item_src[s] = item_reg[s-1];
        end
    end

    always_comb
    begin
        rdy[DIV_STAGES] = out_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--)
        begin
            rdy[s] = !v_reg[s] || rdy[s+1];
        end
    end

    always_comb
    begin
        logic [DIV_WIDTH:0] trial;
        dvsr_t              rem;
        quo_t               quo;
        trial = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem = rem_src[s];
            quo = quo_src[s];
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                if (s * DIV_STEPS + k < QUO_WIDTH)
                begin
                    trial = {rem, 1'b0};
                    if (trial >= {1'b0, item_src[s].dvsr})
                    begin
                        trial = trial - {1'b0, item_src[s].dvsr};
                        quo   = {quo[QUO_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        quo   = {quo[QUO_WIDTH-2:0], 1'b0};
                    end
                    rem = trial[DIV_WIDTH-1:0];
                end
            end
            rem_next[s] = rem;
            quo_next[s] = quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                if (rdy[s])
                begin
                    v_reg[s] <= v_src[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (rdy[s] && v_src[s])
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                item_reg[s] <= item_src[s];
            end
        end
    end

    assign in_ready           = rdy[0];
    assign out_valid          = v_reg[DIV_STAGES-1];
    assign out_item.quo       = quo_reg[DIV_STAGES-1];
    assign out_item.phi_base  = item_reg[DIV_STAGES-1].phi_base;
    assign out_item.rpos      = item_reg[DIV_STAGES-1].rpos;
    assign out_item.grad      = item_reg[DIV_STAGES-1].grad;
    assign out_item.last      = item_reg[DIV_STAGES-1].last;

endmodule

// File: src/koren_lg_mul.sv
`timescale 1ns / 1ps
// Back end: apply the ratio-side bound, multiply by the gradient, saturate.
// Depends on koren_lg_pkg and koren_lg_out_if.
module koren_lg_mul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ratio_en,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  koren_lg_pkg::div_item_t in_item,
    koren_lg_out_if.source          limited
);
    import koren_lg_pkg::*;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: final limiter
    logic  v1_reg;
    lim_t  phi1_reg, phi1_next;
    data_t grad1_reg;
    logic  last1_reg;
    lim_t  quo_ext;

    // stage 2: magnitudes
    logic                  v2_reg;
    logic [LIM_WIDTH-2:0]  a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic                  neg2_reg;
    lim_t                  phi2_reg;
    logic                  last2_reg;

    // stage 3: product
    logic              v3_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              neg3_reg;
    lim_t              phi3_reg;
    logic              last3_reg;

    // stage 4: output register
    logic                 v4_reg;
    data_t                res_reg, res_next;
    lim_t                 phi4_reg;
    logic                 sat_reg, sat_next;
    logic                 last4_reg;
    logic [SHIFTED_W-1:0] q, lim, mag;

    assign rdy4     = !v4_reg || limited.ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        quo_ext   = lim_t'({1'b0, in_item.quo});
        phi1_next = (ratio_en && in_item.rpos && (quo_ext < in_item.phi_base))
                  ? quo_ext : in_item.phi_base;
    end

    always_comb
    begin
        a_next = phi1_reg[LIM_WIDTH-1] ? (LIM_WIDTH-1)'(-phi1_reg)
                                       : (LIM_WIDTH-1)'(phi1_reg);
        b_next = grad1_reg[DATA_WIDTH-1] ? DATA_WIDTH'(-grad1_reg)
                                         : DATA_WIDTH'(grad1_reg);
    end

    assign prod_next = PROD_W'(a_reg) * PROD_W'(b_reg);

    always_comb
    begin
        q        = prod_reg[PROD_W-1:FRAC_BITS];
        lim      = (SHIFTED_W'(1) << (DATA_WIDTH - 1)) - SHIFTED_W'(!neg3_reg);
        sat_next = q > lim;
        mag      = sat_next ? lim : q;
        res_next = neg3_reg ? data_t'(SHIFTED_W'(0) - mag) : data_t'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            phi1_reg  <= phi1_next;
            grad1_reg <= in_item.grad;
            last1_reg <= in_item.last;
        end
        if (rdy2 && v1_reg)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            neg2_reg  <= phi1_reg[LIM_WIDTH-1] ^ grad1_reg[DATA_WIDTH-1];
            phi2_reg  <= phi1_reg;
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            prod_reg  <= prod_next;
            neg3_reg  <= neg2_reg;
            phi3_reg  <= phi2_reg;
            last3_reg <= last2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            res_reg   <= res_next;
            phi4_reg  <= phi3_reg;
            sat_reg   <= sat_next;
            last4_reg <= last3_reg;
        end
    end

    assign limited.valid            = v4_reg;
    assign limited.limited_gradient = res_reg;
    assign limited.limiter_value    = phi4_reg;
    assign limited.saturated        = sat_reg;
    assign limited.last_out         = last4_reg;

    a_phi_range: assert property (@(posedge clk) disable iff (!rst_n)
        limited.valid |-> (limited.limiter_value >= lim_t'(PHI_MIN)
                           && limited.limiter_value <= lim_t'(PHI_MAX)))
        else $error("limiter value out of range");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (limited.valid && limited.saturated) |->
            (limited.limited_gradient == DATA_MAX || limited.limited_gradient == DATA_MIN))
        else $error("saturated result not at a range limit");

    a_zero_phi: assert property (@(posedge clk) disable iff (!rst_n)
        (limited.valid && limited.limiter_value == lim_t'(0)) |->
            (limited.limited_gradient == data_t'(0) && !limited.saturated))
        else $error("zero limiter gave nonzero result");

    a_bound_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (rdy1 && in_valid) |=> (phi1_reg <= $past(in_item.phi_base)))
        else $error("ratio-side bound raised the limiter");

endmodule
